// ===== rtl/ip_flow_accounting_table_unit_defines.svh =====
// Assertion macros for the flow accounting table
`ifndef IP_FLOW_ACCOUNTING_TABLE_UNIT_DEFINES_SVH
`define IP_FLOW_ACCOUNTING_TABLE_UNIT_DEFINES_SVH
// implication checked every clock, off during reset
`define FAT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/ifat_pkg.sv =====
// ----------------------------------------------------------------------------
// ifat_pkg
// Shared codes and types of the flow accounting table.
// ----------------------------------------------------------------------------
`default_nettype none
package ifat_pkg;
    localparam logic [1:0] OP_ACCOUNT = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_TOSSED   = 3'd2;
    localparam logic [2:0] ST_FILTERED = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_CREDIT    = 3'd1;
    localparam logic [2:0] CFG_FCOUNT    = 3'd2;
    localparam logic [2:0] CFG_F0_ADDR   = 3'd3;
    localparam logic [2:0] CFG_F0_MASK   = 3'd4;
    localparam logic [2:0] CFG_F1_ADDR   = 3'd5;
    localparam logic [2:0] CFG_F1_MASK   = 3'd6;

    localparam int BUCKET_W = 8;
    localparam int MAX_ENTRIES = 1024;

    function automatic logic [BUCKET_W-1:0] fold_bucket(input logic [31:0] s,
                                                         input logic [31:0] d);
        logic [31:0] x;
        x = s ^ d;
        x = x ^ (x >> 16);
        x = x ^ (x >> 8);
        return x[BUCKET_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/ip_flow_accounting_table_unit.sv =====
// ----------------------------------------------------------------------------
// ip_flow_accounting_table_unit
// Flow accounting hash table with address filters and tossed counters.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_ready) carries one command beat: account a
//  packet, read a slot, or clear. Each accepted beat yields one result beat
//  on out_valid/out_ready. cfg_valid/cfg_ready writes a register by index;
//  write only while idle. A pending write takes priority over a command.
//  Steps: account runs the filter steps (S_F0, S_F1, S_FDONE), then reads
//  the bucket head (S_HEAD), then per chain entry visited one entry memory
//  read (S_RD) then one compare through the shared compare unit (S_CMP),
//  then updates (S_UPD) or inserts (S_INS). A packet filtered out for lack
//  of credit ends after the filter steps. Read uses S_READ1 and S_READ2.
//  Clear and ignored beats go straight to the result. One item at a time;
//  the next beat is taken only after the result is taken.
//  Reset: all buckets empty (256 valid bits cleared at once), counters zero,
//  credit zero. Clear empties the buckets and zeroes the counters likewise
//  and reloads the credit from the configured default. Entry memory is not
//  cleared; only slots below the count are read. A stalled receiver holds
//  the result register; no new beat is taken until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ip_flow_accounting_table_unit_defines.svh"
module ip_flow_accounting_table_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] source_address,
    input  wire logic [31:0] destination_address,
    input  wire logic [15:0] packet_length,
    input  wire logic [1:0]  acl_kind,
    input  wire logic [11:0] acl_number,
    input  wire logic [9:0]  entry_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic             entry_valid,
    output logic [31:0]      entry_source,
    output logic [31:0]      entry_destination,
    output logic [31:0]      entry_packets,
    output logic [31:0]      entry_bytes,
    output logic [11:0]      entry_acl,
    output logic [10:0]      entries_used,
    output logic [31:0]      tossed_packets,
    output logic [31:0]      tossed_bytes,
    output logic [31:0]      tossed_violations
);
    import ifat_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = IW + 1;
    localparam int NB = 1 << BUCKET_W;

    typedef enum logic [3:0] {
        S_IDLE, S_F0, S_F1, S_FDONE, S_HEAD, S_RD, S_CMP, S_UPD, S_INS,
        S_READ1, S_READ2, S_OUT
    } state_t;

    state_t state_reg;

    logic [10:0] thr_reg;
    logic [15:0] cdef_reg;
    logic [1:0]  fcnt_reg;
    logic [31:0] f0a_reg, f0m_reg, f1a_reg, f1m_reg;

    logic [CW-1:0] count_reg;
    logic [15:0]   credit_reg;
    logic [31:0]   lp_reg, lb_reg, lv_reg;
    logic [NB-1:0] hvalid_reg;
    logic [IW-1:0] head_mem [NB];
    logic [31:0] msrc [MAX_ENTRIES];
    logic [31:0] mdst [MAX_ENTRIES];
    logic [31:0] mpkt [MAX_ENTRIES];
    logic [31:0] mbyt [MAX_ENTRIES];
    logic [11:0] macl [MAX_ENTRIES];
    logic [CW-1:0] mnxt [MAX_ENTRIES];

    logic [31:0] src_reg, dst_reg;
    logic [15:0] len_reg;
    logic [11:0] acl_reg;
    logic [IW-1:0] idx_reg;
    logic [BUCKET_W-1:0] bkt_reg;
    logic          hit_reg;
    logic [CW-1:0] e_reg;
    logic [CW-1:0] steps_reg;
    logic [IW-1:0] head_rd_reg;

    logic [31:0] rsrc_reg, rdst_reg, rpkt_reg, rbyt_reg;
    logic [11:0] racl_reg;
    logic [CW-1:0] rnxt_reg;

    logic [2:0]  st_reg;
    logic        ev_reg;
    logic [31:0] es_reg, ed_reg, ep_reg, eb_reg;
    logic [11:0] ea_reg;

    logic cmp_filter;
    logic [31:0] cmp_bsrc, cmp_mask;
    logic cmp_match;
    logic [1:0] nf;
    logic [IW-1:0] e_idx;
    logic ins_ok;

    assign e_idx = e_reg[IW-1:0];
    assign nf = (fcnt_reg > 2'd2) ? 2'd2 : fcnt_reg;
    assign ins_ok = (32'(count_reg) < 32'(thr_reg)) && (count_reg < CW'(MAX_ENTRIES));

    always_comb
    begin
        cmp_filter = 1'b1;
        cmp_bsrc = f0a_reg;
        cmp_mask = f0m_reg;
        case (state_reg)
            S_F0:    begin cmp_bsrc = f0a_reg; cmp_mask = f0m_reg; end
            S_F1:    begin cmp_bsrc = f1a_reg; cmp_mask = f1m_reg; end
            S_CMP:   begin cmp_filter = 1'b0; cmp_bsrc = rsrc_reg; end
            default: cmp_filter = 1'b1;
        endcase
    end

    ifat_cmp u_cmp
    (
        .a_src(src_reg), .a_dst(dst_reg), .a_acl(acl_reg),
        .b_src(cmp_bsrc), .b_dst(rdst_reg), .b_acl(racl_reg),
        .mask(cmp_mask), .filter_mode(cmp_filter), .match(cmp_match)
    );

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign out_valid = (state_reg == S_OUT);

    // memories
    always_ff @(posedge clk)
    begin
        head_rd_reg <= head_mem[bkt_reg];
        rsrc_reg <= msrc[state_reg == S_READ1 ? idx_reg : e_idx];
        rdst_reg <= mdst[state_reg == S_READ1 ? idx_reg : e_idx];
        rpkt_reg <= mpkt[state_reg == S_READ1 ? idx_reg : e_idx];
        rbyt_reg <= mbyt[state_reg == S_READ1 ? idx_reg : e_idx];
        racl_reg <= macl[state_reg == S_READ1 ? idx_reg : e_idx];
        rnxt_reg <= mnxt[e_idx];
        if (state_reg == S_UPD)
        begin
            mpkt[e_idx] <= rpkt_reg + 32'd1;
            mbyt[e_idx] <= rbyt_reg + {16'd0, len_reg};
        end
        if (state_reg == S_INS && ins_ok)
        begin
            msrc[count_reg[IW-1:0]] <= src_reg;
            mdst[count_reg[IW-1:0]] <= dst_reg;
            mpkt[count_reg[IW-1:0]] <= 32'd1;
            mbyt[count_reg[IW-1:0]] <= {16'd0, len_reg};
            macl[count_reg[IW-1:0]] <= acl_reg;
            mnxt[count_reg[IW-1:0]] <= hvalid_reg[bkt_reg] ? {1'b0, head_rd_reg}
                                                           : CW'(MAX_ENTRIES);
            head_mem[bkt_reg] <= count_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            thr_reg <= 11'd512; cdef_reg <= '0; fcnt_reg <= '0;
            f0a_reg <= '0; f0m_reg <= '0; f1a_reg <= '0; f1m_reg <= '0;
            count_reg <= '0; credit_reg <= '0;
            lp_reg <= '0; lb_reg <= '0; lv_reg <= '0;
            hvalid_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            CFG_THRESHOLD: thr_reg <= cfg_data[10:0];
                            CFG_CREDIT:
                            begin
                                cdef_reg <= cfg_data[15:0];
                                credit_reg <= cfg_data[15:0];
                            end
                            CFG_FCOUNT:  fcnt_reg <= cfg_data[1:0];
                            CFG_F0_ADDR: f0a_reg <= cfg_data;
                            CFG_F0_MASK: f0m_reg <= cfg_data;
                            CFG_F1_ADDR: f1a_reg <= cfg_data;
                            CFG_F1_MASK: f1m_reg <= cfg_data;
                            default: ;
                        endcase
                    end
                    else if (in_valid)
                    begin
                        src_reg <= source_address;
                        dst_reg <= destination_address;
                        len_reg <= packet_length;
                        acl_reg <= (acl_kind == 2'd1) ? acl_number : 12'd0;
                        idx_reg <= entry_index[IW-1:0];
                        bkt_reg <= fold_bucket(source_address, destination_address);
                        hit_reg <= 1'b0;
                        ev_reg <= 1'b0;
                        es_reg <= '0; ed_reg <= '0; ep_reg <= '0; eb_reg <= '0;
                        ea_reg <= '0;
                        if (operation == OP_ACCOUNT)
                        begin
                            if (acl_kind[1])
                            begin
                                st_reg <= ST_IGNORED;
                                state_reg <= S_OUT;
                            end
                            else
                                state_reg <= S_F0;
                        end
                        else if (operation == OP_READ)
                        begin
                            st_reg <= ST_READ;
                            state_reg <= S_READ1;
                        end
                        else if (operation == OP_CLEAR)
                        begin
                            hvalid_reg <= '0;
                            count_reg <= '0;
                            lp_reg <= '0; lb_reg <= '0; lv_reg <= '0;
                            credit_reg <= cdef_reg;
                            st_reg <= ST_CLEARED;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            st_reg <= ST_IGNORED;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_F0:
                begin
                    if (nf != 2'd0 && cmp_match)
                        hit_reg <= 1'b1;
                    state_reg <= S_F1;
                end
                S_F1:
                begin
                    if (nf == 2'd2 && cmp_match)
                        hit_reg <= 1'b1;
                    state_reg <= S_FDONE;
                end
                S_FDONE:
                begin
                    if (nf != 2'd0 && !hit_reg)
                    begin
                        if (credit_reg == 16'd0)
                        begin
                            st_reg <= ST_FILTERED;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            credit_reg <= credit_reg - 16'd1;
                            state_reg <= S_HEAD;
                        end
                    end
                    else
                        state_reg <= S_HEAD;
                    steps_reg <= '0;
                end
                S_HEAD:
                begin
                    // head_rd_reg valid now
                    e_reg <= hvalid_reg[bkt_reg] ? {1'b0, head_rd_reg}
                                                 : CW'(MAX_ENTRIES);
                    state_reg <= S_RD;
                    if (!hvalid_reg[bkt_reg])
                        state_reg <= S_INS;
                    else if ({1'b0, head_rd_reg} >= count_reg)
                        state_reg <= S_INS;
                end
                S_RD:
                    state_reg <= S_CMP;
                S_CMP:
                begin
                    if (cmp_match)
                    begin
                        st_reg <= ST_UPDATED;
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        e_reg <= rnxt_reg;
                        steps_reg <= steps_reg + CW'(1);
                        if (rnxt_reg < count_reg &&
                            steps_reg < CW'(MAX_ENTRIES - 1))
                            state_reg <= S_RD;
                        else
                            state_reg <= S_INS;
                    end
                end
                S_UPD:
                    state_reg <= S_OUT;
                S_INS:
                begin
                    if (ins_ok)
                    begin
                        count_reg <= count_reg + CW'(1);
                        hvalid_reg[bkt_reg] <= 1'b1;
                        st_reg <= ST_NEW;
                    end
                    else
                    begin
                        st_reg <= ST_TOSSED;
                        if (acl_reg == 12'd0)
                        begin
                            lp_reg <= lp_reg + 32'd1;
                            lb_reg <= lb_reg + {16'd0, len_reg};
                        end
                        else
                            lv_reg <= lv_reg + 32'd1;
                    end
                    state_reg <= S_OUT;
                end
                S_READ1:
                    state_reg <= S_READ2;
                S_READ2:
                begin
                    if ({1'b0, idx_reg} < count_reg && {1'b0, idx_reg} < CW'(MAX_ENTRIES))
                    begin
                        ev_reg <= 1'b1;
                        es_reg <= rsrc_reg; ed_reg <= rdst_reg;
                        ep_reg <= rpkt_reg; eb_reg <= rbyt_reg;
                        ea_reg <= racl_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign status = st_reg;
    assign entry_valid = ev_reg;
    assign entry_source = es_reg;
    assign entry_destination = ed_reg;
    assign entry_packets = ep_reg;
    assign entry_bytes = eb_reg;
    assign entry_acl = ea_reg;
    assign entries_used = 11'(count_reg);
    assign tossed_packets = lp_reg;
    assign tossed_bytes = lb_reg;
    assign tossed_violations = lv_reg;

    `FAT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(MAX_ENTRIES),
        "entry count above table size")
    `FAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status),
        "result dropped while stalled")
    `FAT_ASSERT_IMP(a_ready_excl, in_ready, !out_valid,
        "ready while result pending")
endmodule
`default_nettype wire

// ===== rtl/ifat_cmp.sv =====
// ----------------------------------------------------------------------------
// ifat_cmp
// Shared key compare unit: filter match and chain entry match.
// ----------------------------------------------------------------------------
`default_nettype none
module ifat_cmp
(
    input  wire logic [31:0] a_src,
    input  wire logic [31:0] a_dst,
    input  wire logic [11:0] a_acl,
    input  wire logic [31:0] b_src,
    input  wire logic [31:0] b_dst,
    input  wire logic [11:0] b_acl,
    input  wire logic [31:0] mask,
    input  wire logic        filter_mode,
    output logic             match
);
    always_comb
    begin
        if (filter_mode)
            match = ((a_src & mask) == b_src) || ((a_dst & mask) == b_src);
        else
            match = (a_src == b_src) && (a_dst == b_dst) && (a_acl == b_acl);
    end
endmodule
`default_nettype wire
